>>> design/weights_stream_checker_crc32_macros.svh
// Assertion helpers shared by the checker RTL.
`ifndef WEIGHTS_STREAM_CHECKER_CRC32_MACROS_SVH
`define WEIGHTS_STREAM_CHECKER_CRC32_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define WSCC_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define WSCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/wscc_pkg.sv
`default_nettype none

package wscc_pkg;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // Register index, taken from paddr[2]
   localparam logic REG_EXP_COUNT = 1'b0;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   localparam logic [3:0][7:0] MAGIC_BYTES = {8'h31, 8'h57, 8'h54, 8'h4C};

   typedef enum logic [2:0] {
      ST_IN_PROGRESS  = 3'd0,
      ST_OK           = 3'd1,
      ST_BAD_MAGIC    = 3'd2,
      ST_COUNT_MISMATCH = 3'd3,
      ST_TRUNCATED    = 3'd4,
      ST_CRC_MISMATCH = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      FK_NONE   = 3'd0,
      FK_COUNT  = 3'd1,
      FK_NDIMS  = 3'd2,
      FK_DIM    = 3'd3,
      FK_NUMEL  = 3'd4
   } kind_type;

   // Reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> design/wscc_channels.sv
`default_nettype none

interface wscc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_last;

   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface wscc_rsp_if;
   logic                 valid;
   logic                 ready;
   wscc_pkg::status_type status;
   logic                 done_res;
   logic [31:0]          tensor_index;
   wscc_pkg::kind_type   field_kind;
   logic [63:0]          field_value;

   modport source (output valid, output status, output done_res, output tensor_index,
                   output field_kind, output field_value, input ready);
   modport sink   (input valid, input status, input done_res, input tensor_index,
                   input field_kind, input field_value, output ready);
endinterface

`default_nettype wire

>>> design/weights_stream_checker_crc32.sv
// Weights file stream checker with CRC-32.
// req_if carries the file one byte per transaction (data_byte, is_last on the
// final byte). rsp_if returns exactly one transaction per accepted byte: the
// sticky status, done_res, the current tensor index and any header field
// (tensor count, ndims, dim, numel) that completed with that byte.
// The APB port holds one register, the expected tensor count, at address 0.
// The response is registered and appears in the cycle after the byte is accepted.
// One byte per cycle while the response register can take it; the byte-wise CRC,
// field accumulator and counters all update in a single register-to-register pass.
// The response sits in an output register; a new byte is accepted whenever
// that register is empty or is being drained in the same cycle, so a stalled
// receiver stalls the input only once the register is full.
// Reset (synchronous, active high) returns the parser to the magic phase,
// presets the CRC to all ones, clears the expected count, the sticky status
// and the output valid. Once a status other than in-progress is set, later
// bytes are still consumed and each answered with the same status and done.
`default_nettype none
`include "weights_stream_checker_crc32_macros.svh"

module weights_stream_checker_crc32 (
   input  wire logic                          clock,
   input  wire logic                          reset,
   wscc_req_if.sink                           req_if,
   wscc_rsp_if.source                         rsp_if,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [wscc_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [wscc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [wscc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                               pready
);
   import wscc_pkg::*;

   typedef enum logic [2:0] {
      PH_MAGIC, PH_COUNT, PH_NDIMS, PH_DIM, PH_NUMEL, PH_DATA, PH_CRC
   } phase_type;

   // Parser state
   phase_type   phase_ff, phase_in;
   logic [31:0] crc_ff, crc_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  byte_cnt_ff, byte_cnt_in;
   logic [31:0] tensors_left_ff, tensors_left_in;
   logic [31:0] cur_tensor_ff, cur_tensor_in;
   logic [31:0] dims_left_ff, dims_left_in;
   logic [63:0] elems_left_ff, elems_left_in;
   logic [1:0]  byte_in_elem_ff, byte_in_elem_in;
   status_type  sticky_ff, sticky_in;
   logic [31:0] exp_count_ff, exp_count_in;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff;
   logic        rsp_done_ff;
   logic [31:0] rsp_index_ff;
   kind_type    rsp_kind_ff, rsp_kind_in;
   logic [63:0] rsp_value_ff, rsp_value_in;

   logic        req_accept;
   logic        csr_write;
   logic [7:0]  b;
   logic [63:0] acc_merged;
   logic [3:0]  byte_cnt_inc;
   logic        done4, done8;
   logic [31:0] tl_dec;
   logic [1:0]  bie_inc;

   // Accept while the output register is empty or draining
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.done_res     = rsp_done_ff;
   assign rsp_if.tensor_index = rsp_index_ff;
   assign rsp_if.field_kind   = rsp_kind_ff;
   assign rsp_if.field_value  = rsp_value_ff;

   // APB: single register, decoded on the word index bit only
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_EXP_COUNT);
   assign prdata    = (paddr[2] == REG_EXP_COUNT) ? exp_count_ff : '0;
   assign exp_count_in = csr_write ? pwdata : exp_count_ff;

   // Little-endian field assembly: drop the byte into its lane
   assign b            = req_if.data_byte;
   assign acc_merged   = acc_ff | ({56'd0, b} << {byte_cnt_ff[2:0], 3'b000});
   assign byte_cnt_inc = byte_cnt_ff + 4'd1;
   assign done4        = byte_cnt_inc >= 4'd4;
   assign done8        = byte_cnt_inc >= 4'd8;
   assign tl_dec       = tensors_left_ff - 32'd1;
   assign bie_inc      = byte_in_elem_ff + 2'd1;

   always_comb begin
      phase_in        = phase_ff;
      crc_in          = crc_ff;
      acc_in          = acc_ff;
      byte_cnt_in     = byte_cnt_ff;
      tensors_left_in = tensors_left_ff;
      cur_tensor_in   = cur_tensor_ff;
      dims_left_in    = dims_left_ff;
      elems_left_in   = elems_left_ff;
      byte_in_elem_in = byte_in_elem_ff;
      sticky_in       = sticky_ff;
      rsp_kind_in     = FK_NONE;
      rsp_value_in    = '0;

      if (req_accept && sticky_ff == ST_IN_PROGRESS) begin
         // The stored CRC itself stays out of the checksum
         if (phase_ff != PH_CRC) begin
            crc_in = crc_byte(crc_ff, b);
         end

         case (phase_ff)
            PH_MAGIC: begin
               if (b != MAGIC_BYTES[byte_cnt_ff[1:0]]) begin
                  sticky_in = ST_BAD_MAGIC;
               end else if (done4) begin
                  byte_cnt_in = '0;
                  phase_in    = PH_COUNT;
               end else begin
                  byte_cnt_in = byte_cnt_inc;
               end
            end
            PH_COUNT: begin
               if (done4) begin
                  acc_in       = '0;
                  byte_cnt_in  = '0;
                  rsp_kind_in  = FK_COUNT;
                  rsp_value_in = acc_merged;
                  if (acc_merged[31:0] != exp_count_ff) begin
                     sticky_in = ST_COUNT_MISMATCH;
                  end else begin
                     tensors_left_in = acc_merged[31:0];
                     phase_in = (acc_merged[31:0] == 32'd0) ? PH_CRC : PH_NDIMS;
                  end
               end else begin
                  acc_in      = acc_merged;
                  byte_cnt_in = byte_cnt_inc;
               end
            end
            PH_NDIMS: begin
               if (done4) begin
                  acc_in       = '0;
                  byte_cnt_in  = '0;
                  rsp_kind_in  = FK_NDIMS;
                  rsp_value_in = acc_merged;
                  dims_left_in = acc_merged[31:0];
                  phase_in     = (acc_merged[31:0] == 32'd0) ? PH_NUMEL : PH_DIM;
               end else begin
                  acc_in      = acc_merged;
                  byte_cnt_in = byte_cnt_inc;
               end
            end
            PH_DIM: begin
               if (done8) begin
                  acc_in       = '0;
                  byte_cnt_in  = '0;
                  rsp_kind_in  = FK_DIM;
                  rsp_value_in = acc_merged;
                  dims_left_in = dims_left_ff - 32'd1;
                  if (dims_left_ff == 32'd1) begin
                     phase_in = PH_NUMEL;
                  end
               end else begin
                  acc_in      = acc_merged;
                  byte_cnt_in = byte_cnt_inc;
               end
            end
            PH_NUMEL: begin
               if (done8) begin
                  acc_in          = '0;
                  byte_cnt_in     = '0;
                  rsp_kind_in     = FK_NUMEL;
                  rsp_value_in    = acc_merged;
                  elems_left_in   = acc_merged;
                  byte_in_elem_in = '0;
                  if (acc_merged == 64'd0) begin
                     // Empty tensor: close it straight away
                     cur_tensor_in   = cur_tensor_ff + 32'd1;
                     tensors_left_in = tl_dec;
                     phase_in        = (tl_dec == 32'd0) ? PH_CRC : PH_NDIMS;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end else begin
                  acc_in      = acc_merged;
                  byte_cnt_in = byte_cnt_inc;
               end
            end
            PH_DATA: begin
               byte_in_elem_in = bie_inc;
               if (bie_inc == 2'd0) begin
                  elems_left_in = elems_left_ff - 64'd1;
                  if (elems_left_ff == 64'd1) begin
                     cur_tensor_in   = cur_tensor_ff + 32'd1;
                     tensors_left_in = tl_dec;
                     phase_in        = (tl_dec == 32'd0) ? PH_CRC : PH_NDIMS;
                  end
               end
            end
            default: begin
               // Stored CRC, compared against the finalised running value
               if (done4) begin
                  acc_in      = '0;
                  byte_cnt_in = '0;
                  sticky_in   = (acc_merged[31:0] == ~crc_ff) ? ST_OK : ST_CRC_MISMATCH;
               end else begin
                  acc_in      = acc_merged;
                  byte_cnt_in = byte_cnt_inc;
               end
            end
         endcase

         // File ended with the parse unfinished
         if (req_if.is_last && sticky_in == ST_IN_PROGRESS) begin
            sticky_in = ST_TRUNCATED;
         end
      end
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_MAGIC;
         crc_ff          <= CRC_INIT;
         acc_ff          <= '0;
         byte_cnt_ff     <= '0;
         tensors_left_ff <= '0;
         cur_tensor_ff   <= '0;
         dims_left_ff    <= '0;
         elems_left_ff   <= '0;
         byte_in_elem_ff <= '0;
         sticky_ff       <= ST_IN_PROGRESS;
         exp_count_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         crc_ff          <= crc_in;
         acc_ff          <= acc_in;
         byte_cnt_ff     <= byte_cnt_in;
         tensors_left_ff <= tensors_left_in;
         cur_tensor_ff   <= cur_tensor_in;
         dims_left_ff    <= dims_left_in;
         elems_left_ff   <= elems_left_in;
         byte_in_elem_ff <= byte_in_elem_in;
         sticky_ff       <= sticky_in;
         exp_count_ff    <= exp_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      // Response payload: load with each accepted transaction, hold otherwise
      if (req_accept) begin
         rsp_status_ff <= sticky_in;
         rsp_done_ff   <= (sticky_in != ST_IN_PROGRESS);
         rsp_index_ff  <= cur_tensor_in;
         rsp_kind_ff   <= rsp_kind_in;
         rsp_value_ff  <= rsp_value_in;
      end
   end

   // A final status never changes until reset
   `WSCC_ASSERT_RST(a_sticky_holds, clock, reset,
      (sticky_ff != ST_IN_PROGRESS) |=> $stable(sticky_ff), "sticky status changed")
   // Data phase always has elements outstanding
   `WSCC_ASSERT_RST(a_data_nonempty, clock, reset,
      (phase_ff == PH_DATA) |-> (elems_left_ff != 64'd0), "data phase with no elements")
   // done_res tracks the status carried with it
   `WSCC_ASSERT_RST(a_done_matches, clock, reset,
      rsp_valid_ff |-> (rsp_done_ff == (rsp_status_ff != ST_IN_PROGRESS)), "done/status skew")
   // No field value without a field kind
   `WSCC_ASSERT_RST(a_value_zero, clock, reset,
      (rsp_valid_ff && rsp_kind_ff == FK_NONE) |-> (rsp_value_ff == 64'd0),
      "field value without field")
   // A full, stalled output register blocks the input
   `WSCC_ASSERT_ALWAYS(a_no_overrun, clock,
      (rsp_valid_ff && !rsp_if.ready) |-> !req_accept, "response overwritten")

endmodule

`default_nettype wire
